// ----- sv/pvom_pkg.sv -----
// Shared constants, types and functions of the point voxel occupancy marker.
package pvom_pkg;

	localparam int CELLS_PER_AXIS = 16;
	localparam int IDX_W          = 6;
	localparam int COORD_W        = 32;
	localparam int CS_W           = 31;
	localparam int QUO_W          = $clog2(CELLS_PER_AXIS + 1);
	localparam int TOTAL_CELLS    = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
	localparam int ADDR_W         = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
	localparam int REM_W          = CS_W + QUO_W;
	localparam int D_W            = COORD_W + 2;
	localparam int CMP_W          = (REM_W > D_W) ? REM_W : D_W;
	localparam int B_W            = COORD_W + 3;

	localparam logic [0:0] REG_GRID_ORIGIN = 1'b0;
	localparam logic [0:0] REG_CELL_SIZE   = 1'b1;

	localparam logic signed [COORD_W-1:0] ORIGIN_RST = -32'sd655360;
	localparam logic [CS_W-1:0]           CS_RST     = 31'd65536;

	typedef struct packed {
		logic [IDX_W-1:0]          lo;
		logic                      two;
		logic signed [COORD_W-1:0] min0;
		logic signed [COORD_W-1:0] max0;
		logic signed [COORD_W-1:0] min1;
		logic signed [COORD_W-1:0] max1;
	} axis_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [B_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if ((&v[B_W-1:COORD_W-1]) || !(|v[B_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else if (v[B_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] i,
		input logic [IDX_W-1:0] j, input logic [IDX_W-1:0] k);
		int a;
		a = (int'(i) * CELLS_PER_AXIS + int'(j)) * CELLS_PER_AXIS + int'(k);
		return ADDR_W'(a);
	endfunction

endpackage

// ----- sv/pvom_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pvom_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/point_voxel_occupancy_marker.sv -----
// Top level: locates a point in a uniform grid, marks the cells and reports every hit.
//
// After reset the block sweeps the occupancy memory clear, one cell a cycle (4096 cells at
// 16 cells per axis), with busy high. A point is taken when start is high and busy is low.
// It does the range check, then the shared-step division on all three axes, one quotient
// bit per cycle, then forms the bounds and issues one occupancy read per hit cell
// (1 to 8 cells, at most two per axis); each result appears
// one cycle after its read, on strobe, for exactly one cycle, so the receiver must take it.
// A point outside the grid gives no result and frees the block after the range check.
// Write configuration only while busy is low.
module point_voxel_occupancy_marker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [pvom_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pvom_pkg::COORD_W-1:0]   point_y,
	input  logic signed [pvom_pkg::COORD_W-1:0]   point_z,
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_idx,
	input  logic [pvom_pkg::COORD_W-1:0]          cfg_wdata,
	output logic                                  strobe,
	output logic [pvom_pkg::IDX_W-1:0]            cell_i,
	output logic [pvom_pkg::IDX_W-1:0]            cell_j,
	output logic [pvom_pkg::IDX_W-1:0]            cell_k,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_x_min,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_y_min,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_z_min,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_x_max,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_y_max,
	output logic signed [pvom_pkg::COORD_W-1:0]   box_z_max,
	output logic                                  newly_set,
	output logic                                  last_hit
);
	import pvom_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                     state_q;
	logic signed [COORD_W-1:0]  origin_q;
	logic [CS_W-1:0]            cs_q;
	logic [ADDR_W-1:0]          clr_q;
	logic signed [COORD_W-1:0]  p_q   [3];
	logic signed [D_W-1:0]      d_q   [3];
	logic [REM_W-1:0]           rem_q [3];
	logic [QUO_W-1:0]           quo_q [3];
	logic [REM_W-1:0]           dv_q;
	axis_t                      ax_q  [3];
	logic                       cnt_q [3];

	logic                       valid_s1;
	logic                       last_s1;
	logic [IDX_W-1:0]           idx_s1 [3];
	logic signed [COORD_W-1:0]  min_s1 [3];
	logic signed [COORD_W-1:0]  max_s1 [3];
	logic [ADDR_W-1:0]          addr_s1;

	logic signed [COORD_W-1:0]  pin [3];
	logic [CMP_W-1:0]           ncs;
	logic                       in_grid;
	axis_t                      ax_d [3];
	logic [IDX_W-1:0]           sel_idx [3];
	logic [ADDR_W-1:0]          rd_addr;
	logic                       emit_last;
	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic                       ram_wdata;
	logic                       ram_rdata;

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;
	assign busy   = (state_q != ST_IDLE);

	assign ncs = CMP_W'(cs_q) * CMP_W'(CELLS_PER_AXIS);

	always_comb begin
		in_grid = (cs_q != '0);
		for (int a = 0; a < 3; a++) begin
			if (d_q[a][D_W-1] || (CMP_W'(d_q[a]) > ncs)) begin
				in_grid = 1'b0;
			end
		end
	end

	always_comb begin
		logic shf;
		logic signed [B_W-1:0] pb;
		logic signed [B_W-1:0] base;
		logic signed [B_W-1:0] csb;
		for (int a = 0; a < 3; a++) begin
			shf  = (rem_q[a] == '0) && (quo_q[a] != '0);
			pb   = B_W'(p_q[a]);
			csb  = B_W'(cs_q);
			base = pb - $signed(B_W'(rem_q[a]));
			ax_d[a].lo   = IDX_W'(quo_q[a] - QUO_W'(shf));
			ax_d[a].two  = shf && (quo_q[a] < QUO_W'(CELLS_PER_AXIS));
			ax_d[a].min0 = sat32(shf ? base - csb : base);
			ax_d[a].max0 = sat32(shf ? base : base + csb);
			ax_d[a].min1 = p_q[a];
			ax_d[a].max1 = sat32(pb + csb);
		end
	end

	always_comb begin
		emit_last = 1'b1;
		for (int a = 0; a < 3; a++) begin
			sel_idx[a] = ax_q[a].lo + IDX_W'(cnt_q[a]);
			if (cnt_q[a] != ax_q[a].two) begin
				emit_last = 1'b0;
			end
		end
		rd_addr = cell_addr(sel_idx[0], sel_idx[1], sel_idx[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= ORIGIN_RST;
			cs_q     <= CS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_ORIGIN: origin_q <= cfg_wdata;
				REG_CELL_SIZE:   cs_q     <= cfg_wdata[CS_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			valid_s1 <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				cnt_q[a] <= 1'b0;
			end
		end else begin
			valid_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TOTAL_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= in_grid ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (dv_q == REM_W'(cs_q)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
					for (int a = 0; a < 3; a++) begin
						cnt_q[a] <= 1'b0;
					end
				end
				ST_EMIT: begin
					valid_s1 <= 1'b1;
					if (emit_last) begin
						state_q <= ST_IDLE;
					end
					if (cnt_q[2] != ax_q[2].two) begin
						cnt_q[2] <= 1'b1;
					end else begin
						cnt_q[2] <= 1'b0;
						if (cnt_q[1] != ax_q[1].two) begin
							cnt_q[1] <= 1'b1;
						end else begin
							cnt_q[1] <= 1'b0;
							cnt_q[0] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int a = 0; a < 3; a++) begin
					p_q[a] <= pin[a];
					d_q[a] <= D_W'(pin[a]) - D_W'(origin_q);
				end
			end
			ST_CHECK: begin
				dv_q <= REM_W'(cs_q) << (QUO_W - 1);
				for (int a = 0; a < 3; a++) begin
					rem_q[a] <= REM_W'(d_q[a]);
					quo_q[a] <= '0;
				end
			end
			ST_DIV: begin
				dv_q <= dv_q >> 1;
				for (int a = 0; a < 3; a++) begin
					if (rem_q[a] >= dv_q) begin
						rem_q[a] <= rem_q[a] - dv_q;
					end
					quo_q[a] <= (quo_q[a] << 1) | QUO_W'(rem_q[a] >= dv_q);
				end
			end
			ST_FIN: begin
				for (int a = 0; a < 3; a++) begin
					ax_q[a] <= ax_d[a];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		last_s1 <= emit_last;
		addr_s1 <= rd_addr;
		for (int a = 0; a < 3; a++) begin
			idx_s1[a] <= sel_idx[a];
			min_s1[a] <= cnt_q[a] ? ax_q[a].min1 : ax_q[a].min0;
			max_s1[a] <= cnt_q[a] ? ax_q[a].max1 : ax_q[a].max0;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = valid_s1;
			ram_waddr = addr_s1;
			ram_wdata = 1'b1;
		end
	end

	pvom_ram #(
		.WIDTH(1),
		.DEPTH(TOTAL_CELLS)
	) u_occ (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign strobe    = valid_s1;
	assign cell_i    = idx_s1[0];
	assign cell_j    = idx_s1[1];
	assign cell_k    = idx_s1[2];
	assign box_x_min = min_s1[0];
	assign box_y_min = min_s1[1];
	assign box_z_min = min_s1[2];
	assign box_x_max = max_s1[0];
	assign box_y_max = max_s1[1];
	assign box_z_max = max_s1[2];
	assign newly_set = ~ram_rdata;
	assign last_hit  = last_s1;
endmodule

// ----- sv/pvom_checker.sv -----
// Port-level assertions for the point voxel occupancy marker, with its bind.
module pvom_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                strobe,
	input logic                                last_hit,
	input logic [pvom_pkg::IDX_W-1:0]          cell_i,
	input logic [pvom_pkg::IDX_W-1:0]          cell_j,
	input logic [pvom_pkg::IDX_W-1:0]          cell_k,
	input logic signed [pvom_pkg::COORD_W-1:0] box_x_min,
	input logic signed [pvom_pkg::COORD_W-1:0] box_x_max
);
	import pvom_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	a_hits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_hit |=> strobe)
		else $error("gap inside the hits of one item");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (cell_i < IDX_W'(CELLS_PER_AXIS)) && (cell_j < IDX_W'(CELLS_PER_AXIS))
			&& (cell_k < IDX_W'(CELLS_PER_AXIS)))
		else $error("cell index outside grid");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> box_x_max >= box_x_min)
		else $error("cell bounds reversed");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without work in progress");
endmodule

bind point_voxel_occupancy_marker pvom_checker u_pvom_checker (.*);
